### hw/rtl/calendar_date_counter_macros.svh
// Assertion macros for the calendar date counter RTL, used by caldc_core.
// Sampled on aclk and disabled while aresetn is low; expects both in scope.
`ifndef CALENDAR_DATE_COUNTER_MACROS_SVH
`define CALENDAR_DATE_COUNTER_MACROS_SVH
`ifndef ASSERT_OFF
`define CALDC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define CALDC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CALDC_ASSERT(name, prop, msg)
`define CALDC_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

### hw/rtl/caldc_pkg.sv
// Shared types, constants and functions for the calendar date counter.
// No dependencies; imported by every module of the block.
package caldc_pkg;

    localparam int YEAR_BITS_DEF = 16;

    typedef enum logic [1:0] {
        OP_FWD  = 2'd0,
        OP_BACK = 2'd1,
        OP_LOAD = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_DEFAULT_DAY   = 2'd0,
        CFG_DEFAULT_MONTH = 2'd1,
        CFG_DEFAULT_YEAR  = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    localparam int DAY_BITS   = 5;
    localparam int MONTH_BITS = 4;

    localparam logic [DAY_BITS-1:0]   FIRST_DAY       = 5'd1;
    localparam logic [MONTH_BITS-1:0] FIRST_MONTH     = 4'd1;
    localparam logic [MONTH_BITS-1:0] MONTH_FEB       = 4'd2;
    localparam logic [MONTH_BITS-1:0] MONTH_DEC       = 4'd12;
    localparam logic [DAY_BITS-1:0]   DAYS_LONG       = 5'd31;
    localparam logic [DAY_BITS-1:0]   DAYS_SHORT      = 5'd30;
    localparam logic [DAY_BITS-1:0]   DAYS_FEB        = 5'd28;
    localparam logic [DAY_BITS-1:0]   DAYS_FEB_LEAP   = 5'd29;
    localparam logic [DAY_BITS-1:0]   DAYS_NONE       = 5'd0;

    // A year divisible by 100 is divisible by 4 and 25, by 400 also by 16
    localparam longint unsigned CENTURY_ODD = 25;

    localparam logic [DAY_BITS-1:0]   RST_DAY   = FIRST_DAY;
    localparam logic [MONTH_BITS-1:0] RST_MONTH = FIRST_MONTH;
    localparam int                    RST_YEAR  = 2000;
    localparam logic                  RST_LEAP  = 1'b1;

    // Length of month m; zero for a month number outside 1..12
    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                      input logic leap);
        logic [DAY_BITS-1:0] len;
        case (m)
            4'd2:                         len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
            4'd4, 4'd6, 4'd9, 4'd11:      len = DAYS_SHORT;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:           len = DAYS_LONG;
            default:                      len = DAYS_NONE;
        endcase
        return len;
    endfunction

    // Inverse of an odd constant modulo 2^64 by Newton steps (3 -> 96 bits)
    function automatic logic [63:0] odd_inverse(input logic [63:0] a);
        logic [63:0] x;
        x = a;
        for (int i = 0; i < 5; i++) begin
            x = x * (64'd2 - a * x);
        end
        return x;
    endfunction

endpackage

### hw/rtl/calendar_date_counter.sv
// Gregorian calendar date counter: step forward, step back or load a date.
// An accepted input waits in the input register, its result in the output register.
// Throughput: one transaction per cycle if m_ready is high; a waiting result lets one
// more input into the input register, then s_ready follows m_ready in the same cycle.
// Reset (aresetn low, synchronous): date 1/1/2000, defaults 1/1/2000, channels empty.
// Depends on caldc_pkg and caldc_core.
module calendar_date_counter
    import caldc_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [YEAR_BITS-1:0]  cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [DAY_BITS-1:0]   s_load_day,
    input  logic [MONTH_BITS-1:0] s_load_month,
    input  logic [YEAR_BITS-1:0]  s_load_year,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DAY_BITS-1:0]   m_cur_day,
    output logic [MONTH_BITS-1:0] m_cur_month,
    output logic [YEAR_BITS-1:0]  m_cur_year,
    output logic                  m_bad_date,
    output logic                  m_is_leap
);

    logic [DAY_BITS-1:0]   default_day_reg;
    logic [MONTH_BITS-1:0] default_month_reg;
    logic [YEAR_BITS-1:0]  default_year_reg;

    logic                  in_valid_reg;
    logic [1:0]            in_op_reg;
    logic [DAY_BITS-1:0]   in_day_reg;
    logic [MONTH_BITS-1:0] in_month_reg;
    logic [YEAR_BITS-1:0]  in_year_reg;

    logic                  out_valid_reg;
    logic [DAY_BITS-1:0]   out_day_reg;
    logic [MONTH_BITS-1:0] out_month_reg;
    logic [YEAR_BITS-1:0]  out_year_reg;
    logic                  out_bad_reg;
    logic                  out_leap_reg;

    logic                  advance;
    logic                  s_take;
    logic [DAY_BITS-1:0]   day_next;
    logic [MONTH_BITS-1:0] month_next;
    logic [YEAR_BITS-1:0]  year_next;
    logic                  leap_next;
    logic                  bad_next;

    // Advance when an item is held and the result slot is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_day_reg   <= RST_DAY;
            default_month_reg <= RST_MONTH;
            default_year_reg  <= YEAR_BITS'(RST_YEAR);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEFAULT_DAY:   default_day_reg   <= cfg_data[DAY_BITS-1:0];
                CFG_DEFAULT_MONTH: default_month_reg <= cfg_data[MONTH_BITS-1:0];
                CFG_DEFAULT_YEAR:  default_year_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_op_reg    <= s_op;
            in_day_reg   <= s_load_day;
            in_month_reg <= s_load_month;
            in_year_reg  <= s_load_year;
        end
    end

    caldc_core #(
        .YEAR_BITS(YEAR_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .op            (in_op_reg),
        .load_day      (in_day_reg),
        .load_month    (in_month_reg),
        .load_year     (in_year_reg),
        .default_day   (default_day_reg),
        .default_month (default_month_reg),
        .default_year  (default_year_reg),
        .day_next      (day_next),
        .month_next    (month_next),
        .year_next     (year_next),
        .leap_next     (leap_next),
        .bad_next      (bad_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_day_reg   <= day_next;
            out_month_reg <= month_next;
            out_year_reg  <= year_next;
            out_bad_reg   <= bad_next;
            out_leap_reg  <= leap_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_cur_day   = out_day_reg;
    assign m_cur_month = out_month_reg;
    assign m_cur_year  = out_year_reg;
    assign m_bad_date  = out_bad_reg;
    assign m_is_leap   = out_leap_reg;

endmodule

### hw/rtl/caldc_leap.sv
// Gregorian leap-year test on a YEAR_BITS wide year.
// Depends on caldc_pkg; divisibility by 25 through a modular inverse multiply.
module caldc_leap
    import caldc_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic [YEAR_BITS-1:0] year,
    output logic                 leap
);

    localparam logic [63:0]          INV64 = odd_inverse(64'(CENTURY_ODD));
    localparam logic [YEAR_BITS-1:0] INV   = INV64[YEAR_BITS-1:0];
    localparam longint unsigned      LIMIT64 =
        ((longint'(1) << YEAR_BITS) - 1) / CENTURY_ODD;
    localparam logic [YEAR_BITS-1:0] LIMIT = LIMIT64[YEAR_BITS-1:0];

    logic [YEAR_BITS-1:0] prod;
    logic                 div25;

    // y * inv(25) mod 2^N stays small exactly for multiples of 25
    assign prod  = year * INV;
    assign div25 = (prod <= LIMIT);
    assign leap  = (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));

endmodule

### hw/rtl/caldc_core.sv
// Date state registers and next-date logic for one transaction.
// Depends on caldc_pkg, caldc_leap and calendar_date_counter_macros.svh.
`include "calendar_date_counter_macros.svh"
module caldc_core
    import caldc_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic [1:0]            op,
    input  logic [DAY_BITS-1:0]   load_day,
    input  logic [MONTH_BITS-1:0] load_month,
    input  logic [YEAR_BITS-1:0]  load_year,
    input  logic [DAY_BITS-1:0]   default_day,
    input  logic [MONTH_BITS-1:0] default_month,
    input  logic [YEAR_BITS-1:0]  default_year,
    output logic [DAY_BITS-1:0]   day_next,
    output logic [MONTH_BITS-1:0] month_next,
    output logic [YEAR_BITS-1:0]  year_next,
    output logic                  leap_next,
    output logic                  bad_next
);

    logic [DAY_BITS-1:0]   day_reg;
    logic [MONTH_BITS-1:0] month_reg;
    logic [YEAR_BITS-1:0]  year_reg;
    logic                  leap_reg;

    logic [YEAR_BITS-1:0]  year_inc;
    logic [YEAR_BITS-1:0]  year_dec;
    logic [YEAR_BITS-1:0]  year_cand;
    logic                  leap_cand;
    logic [DAY_BITS-1:0]   ld_day;
    logic [MONTH_BITS-1:0] ld_month;
    logic [YEAR_BITS-1:0]  ld_year;
    logic                  load_ok;
    logic [DAY_BITS-1:0]   len_cur;
    logic [DAY_BITS-1:0]   len_prev;

    assign year_inc = year_reg + YEAR_BITS'(1);
    assign year_dec = year_reg - YEAR_BITS'(1);

    assign ld_day   = (load_day == '0)   ? default_day   : load_day;
    assign ld_month = (load_month == '0) ? default_month : load_month;
    assign ld_year  = (load_year == '0)  ? default_year  : load_year;

    // One leap unit serves the year this op may move to
    always_comb begin
        case (op)
            OP_FWD:  year_cand = year_inc;
            OP_BACK: year_cand = year_dec;
            OP_LOAD: year_cand = ld_year;
            default: year_cand = year_reg;
        endcase
    end

    caldc_leap #(
        .YEAR_BITS(YEAR_BITS)
    ) u_leap (
        .year(year_cand),
        .leap(leap_cand)
    );

    assign len_cur  = month_len(month_reg, leap_reg);
    assign len_prev = month_len(month_reg - FIRST_MONTH, leap_reg);
    assign load_ok  = (ld_day != '0) && (ld_day <= month_len(ld_month, leap_cand));

    always_comb begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        leap_next  = leap_reg;
        bad_next   = 1'b0;
        case (op)
            OP_FWD: begin
                if (day_reg >= len_cur) begin
                    day_next = FIRST_DAY;
                    if (month_reg >= MONTH_DEC) begin
                        month_next = FIRST_MONTH;
                        year_next  = year_inc;
                        leap_next  = leap_cand;
                    end else begin
                        month_next = month_reg + FIRST_MONTH;
                    end
                end else begin
                    day_next = day_reg + FIRST_DAY;
                end
            end
            OP_BACK: begin
                if (day_reg <= FIRST_DAY) begin
                    if (month_reg <= FIRST_MONTH) begin
                        month_next = MONTH_DEC;
                        year_next  = year_dec;
                        leap_next  = leap_cand;
                        day_next   = month_len(MONTH_DEC, leap_cand);
                    end else begin
                        month_next = month_reg - FIRST_MONTH;
                        day_next   = len_prev;
                    end
                end else begin
                    day_next = day_reg - FIRST_DAY;
                end
            end
            OP_LOAD: begin
                if (load_ok) begin
                    day_next   = ld_day;
                    month_next = ld_month;
                    year_next  = ld_year;
                    leap_next  = leap_cand;
                end else begin
                    bad_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg   <= RST_DAY;
            month_reg <= RST_MONTH;
            year_reg  <= YEAR_BITS'(RST_YEAR);
            leap_reg  <= RST_LEAP;
        end else if (advance) begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            leap_reg  <= leap_next;
        end
    end

    `CALDC_ASSERT(a_month_range, (month_reg >= FIRST_MONTH) && (month_reg <= MONTH_DEC), "month out of range")
    `CALDC_ASSERT(a_day_fits, (day_reg != '0) && (day_reg <= month_len(month_reg, leap_reg)), "day exceeds month length")
    `CALDC_ASSERT_NEXT(a_bad_holds, advance && bad_next, $stable(day_reg) && $stable(month_reg) && $stable(year_reg), "rejected load changed the date")
    `CALDC_ASSERT_NEXT(a_idle_holds, !advance, $stable(year_reg) && $stable(leap_reg), "date moved without a transaction")

endmodule
